/* hw/rtl/hmbox_pkg.sv */
`timescale 1ns / 1ps
package hmbox_pkg;

	// sample and result field widths
	localparam int SAMPLE_BITS   = 16;
	localparam int ROW_BITS      = 12;
	localparam int COL_OUT_BITS  = 10;
	localparam int ROWS_REG_BITS = 13;
	localparam int COLS_REG_BITS = 11;

	// grid limits
	localparam int MAX_ROWS     = 4096;
	localparam int MAX_COLS_DEF = 1024;

	// sums: three samples per column, nine per window
	localparam int COLSUM_BITS = SAMPLE_BITS + 2;
	localparam int SUM_BITS    = SAMPLE_BITS + 4;

	// floor(x / 9) as (x * DIV_MULT) >> DIV_SHIFT, exact for every x below 2**SUM_BITS
	localparam int DIV_SHIFT = SUM_BITS + 3;
	localparam logic [SUM_BITS-1:0] DIV_MULT = SUM_BITS'((2 ** DIV_SHIFT + 8) / 9);
	localparam int PROD_BITS = 2 * SUM_BITS;

	// configuration port
	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;
	localparam logic REG_GRID_ROWS = 1'b0;
	localparam logic REG_GRID_COLS = 1'b1;

	// queue between front and back (depth is a power of two)
	localparam int QDEPTH    = 4;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);

	// configuration as seen by the front
	typedef struct packed {
		logic                     restart;
		logic [ROWS_REG_BITS-1:0] rows;
		logic [COLS_REG_BITS-1:0] cols;
	} hmbox_cfg_t;

	// one classified sample waiting for the back
	typedef struct packed {
		logic                    has_int;
		logic                    has_bdr;
		logic [ROW_BITS-1:0]     row;
		logic [COL_OUT_BITS-1:0] col;
		logic [COLSUM_BITS-1:0]  cs0;
		logic [COLSUM_BITS-1:0]  cs1;
		logic [COLSUM_BITS-1:0]  cs2;
		logic [SAMPLE_BITS-1:0]  raw;
	} hmbox_entry_t;

	typedef struct packed {
		logic         push;
		hmbox_entry_t entry;
	} hmbox_qwr_t;

endpackage

/* hw/rtl/hmbox_ram.sv */
`timescale 1ns / 1ps
module hmbox_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/hmbox_front.sv */
`timescale 1ns / 1ps
module hmbox_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  hmbox_pkg::hmbox_cfg_t            cfg,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [hmbox_pkg::SAMPLE_BITS-1:0] sample_height,
	input  logic [hmbox_pkg::QCNT_BITS-1:0]  q_count,
	output hmbox_pkg::hmbox_qwr_t            qwr
);
	import hmbox_pkg::*;

	localparam int CW = $clog2(MAX_COLS_DEF);
	localparam int DW = ((CW > COLS_REG_BITS) ? CW : COLS_REG_BITS) + 1;
	localparam int RB = ROWS_REG_BITS + 1;

	logic [ROW_BITS-1:0]    row_q;
	logic [CW-1:0]          col_q;
	logic [RB-1:0]          rows_eff;
	logic [DW-1:0]          cols_eff;
	logic                   last_row;
	logic                   last_col;
	logic                   in_acc;
	logic [QCNT_BITS:0]     fill;

	logic                   v_s1;
	logic [ROW_BITS-1:0]    row_s1;
	logic [CW-1:0]          col_s1;
	logic [SAMPLE_BITS-1:0] bot_s1;
	logic                   int_s1;
	logic                   bdr_s1;

	logic [SAMPLE_BITS-1:0] top;
	logic [SAMPLE_BITS-1:0] mid;
	logic [COLSUM_BITS-1:0] colsum;
	logic [COLSUM_BITS-1:0] w1_q;
	logic [COLSUM_BITS-1:0] w2_q;

	// zero counts as one, anything above the maximum as the maximum
	always_comb begin
		if (cfg.rows == '0) begin
			rows_eff = RB'(1);
		end else if (RB'(cfg.rows) > RB'(MAX_ROWS)) begin
			rows_eff = RB'(MAX_ROWS);
		end else begin
			rows_eff = RB'(cfg.rows);
		end
		if (cfg.cols == '0) begin
			cols_eff = DW'(1);
		end else if (DW'(cfg.cols) > DW'(MAX_COLS_DEF)) begin
			cols_eff = DW'(MAX_COLS_DEF);
		end else begin
			cols_eff = DW'(cfg.cols);
		end
	end

	assign last_row = (RB'(row_q) + RB'(1)) >= rows_eff;
	assign last_col = (DW'(col_q) + DW'(1)) >= cols_eff;

	// room is kept for the sample in the read stage as well
	assign fill     = {1'b0, q_count} + (QCNT_BITS + 1)'(v_s1);
	assign in_stall = fill >= (QCNT_BITS + 1)'(QDEPTH);
	assign in_acc   = in_valid && !in_stall;

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg.restart) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_BITS'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// read stage: line store data arrives while the sample sits here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			row_s1 <= row_q;
			col_s1 <= col_q;
			bot_s1 <= sample_height;
			int_s1 <= (row_q >= ROW_BITS'(2)) && (col_q >= CW'(2));
			bdr_s1 <= (row_q == '0) || (col_q == '0) || last_row || last_col;
		end
	end

	// line stores: upper holds row r-2, lower row r-1
	hmbox_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_COLS_DEF)
	) u_upper (
		.clk  (clk),
		.we   (v_s1),
		.waddr(col_s1),
		.wdata(mid),
		.re   (in_acc),
		.raddr(col_q),
		.rdata(top)
	);

	hmbox_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_COLS_DEF)
	) u_lower (
		.clk  (clk),
		.we   (v_s1),
		.waddr(col_s1),
		.wdata(bot_s1),
		.re   (in_acc),
		.raddr(col_q),
		.rdata(mid)
	);

	// column sum and the two previous column sums form the window
	assign colsum = COLSUM_BITS'(top) + COLSUM_BITS'(mid) + COLSUM_BITS'(bot_s1);

	always_ff @(posedge clk) begin
		if (v_s1) begin
			w1_q <= colsum;
			w2_q <= w1_q;
		end
	end

	// push only samples that cause at least one result
	always_comb begin
		qwr.push          = v_s1 && (int_s1 || bdr_s1);
		qwr.entry.has_int = int_s1;
		qwr.entry.has_bdr = bdr_s1;
		qwr.entry.row     = row_s1;
		qwr.entry.col     = COL_OUT_BITS'(col_s1);
		qwr.entry.cs0     = colsum;
		qwr.entry.cs1     = w1_q;
		qwr.entry.cs2     = w2_q;
		qwr.entry.raw     = bot_s1;
	end

endmodule

/* hw/rtl/hmbox_queue.sv */
`timescale 1ns / 1ps
module hmbox_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hmbox_pkg::hmbox_qwr_t           wr,
	input  logic                            pop,
	output hmbox_pkg::hmbox_entry_t         head,
	output logic                            head_valid,
	output logic [hmbox_pkg::QCNT_BITS-1:0] count
);
	import hmbox_pkg::*;

	hmbox_entry_t         entries_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	// pointers wrap on their own since the depth is a power of two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (wr.push && !pop) begin
				count_q <= count_q + QCNT_BITS'(1);
			end else if (!wr.push && pop) begin
				count_q <= count_q - QCNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.push) begin
			entries_q[wr_ptr_q] <= wr.entry;
		end
	end

	assign head       = entries_q[rd_ptr_q];
	assign head_valid = count_q != '0;
	assign count      = count_q;

endmodule

/* hw/rtl/hmbox_back.sv */
`timescale 1ns / 1ps
module hmbox_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  hmbox_pkg::hmbox_entry_t             head,
	input  logic                                head_valid,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [hmbox_pkg::ROW_BITS-1:0]      out_row,
	output logic [hmbox_pkg::COL_OUT_BITS-1:0]  out_col,
	output logic [hmbox_pkg::SAMPLE_BITS-1:0]   out_height,
	output logic                                run_last
);
	import hmbox_pkg::*;

	logic                    adv;
	logic                    issue;
	logic                    issue_int;
	logic                    issue_last;
	logic                    phase_q;

	logic                    v_s1;
	logic                    int_s1;
	logic                    last_s1;
	logic [ROW_BITS-1:0]     row_s1;
	logic [COL_OUT_BITS-1:0] col_s1;
	logic [SUM_BITS-1:0]     sum_s1;
	logic [SAMPLE_BITS-1:0]  raw_s1;

	logic                    v_s2;
	logic                    int_s2;
	logic                    last_s2;
	logic [ROW_BITS-1:0]     row_s2;
	logic [COL_OUT_BITS-1:0] col_s2;
	logic [PROD_BITS-1:0]    prod_s2;
	logic [SAMPLE_BITS-1:0]  raw_s2;

	logic                    v_s3;
	logic                    last_s3;
	logic [ROW_BITS-1:0]     row_s3;
	logic [COL_OUT_BITS-1:0] col_s3;
	logic [SAMPLE_BITS-1:0]  height_s3;

	// whole pipe moves unless the output register is held
	assign adv   = !v_s3 || !out_stall;
	assign issue = adv && head_valid;

	// interior result of the window goes first, own border result second
	always_comb begin
		issue_int  = head.has_int && !phase_q;
		issue_last = !issue_int || !head.has_bdr;
		pop        = issue && issue_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (issue) begin
			phase_q <= !issue_last;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: window sum and coordinates
	always_ff @(posedge clk) begin
		if (adv) begin
			int_s1  <= issue_int;
			last_s1 <= issue_last;
			row_s1  <= issue_int ? head.row - ROW_BITS'(1) : head.row;
			col_s1  <= issue_int ? head.col - COL_OUT_BITS'(1) : head.col;
			sum_s1  <= SUM_BITS'(head.cs0) + SUM_BITS'(head.cs1) + SUM_BITS'(head.cs2);
			raw_s1  <= head.raw;
		end
	end

	// stage 2: multiply by the reciprocal of nine
	always_ff @(posedge clk) begin
		if (adv) begin
			int_s2  <= int_s1;
			last_s2 <= last_s1;
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			prod_s2 <= PROD_BITS'(sum_s1) * PROD_BITS'(DIV_MULT);
			raw_s2  <= raw_s1;
		end
	end

	// stage 3: output register
	always_ff @(posedge clk) begin
		if (adv) begin
			last_s3   <= last_s2;
			row_s3    <= row_s2;
			col_s3    <= col_s2;
			height_s3 <= int_s2 ? prod_s2[DIV_SHIFT +: SAMPLE_BITS] : raw_s2;
		end
	end

	assign out_valid  = v_s3;
	assign out_row    = row_s3;
	assign out_col    = col_s3;
	assign out_height = height_s3;
	assign run_last   = last_s3;

endmodule

/* hw/rtl/heightmap_box_smooth_3x3.sv */
`timescale 1ns / 1ps
// Streaming 3x3 box smoother for a height grid sent in raster order. The block
// takes one sample per cycle while in_stall is low. Border samples come out
// unchanged with their own row and column; an interior sample comes out as
// floor(sum of its 3x3 window / 9) when the sample one row below and one
// column right arrives, ahead of that sample's own result. Samples on the last
// column or the last row, from row 2 and column 2 on, cause two results, and
// the back end emits one result a cycle unless out_stall holds it; a
// four-entry queue between the front (position counters, line store read) and
// the back (window sum, multiply by the reciprocal of nine, output register)
// absorbs short bursts of them. Writing grid_rows (offset 0x0) or grid_cols
// (0x4) restarts the grid at row 0, column 0; write them only while the block
// is idle. The line stores need no clearing after reset.
module heightmap_box_smooth_3x3 (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [hmbox_pkg::ADDR_BITS-1:0]    paddr,
	input  logic [hmbox_pkg::DATA_BITS-1:0]    pwdata,
	output logic [hmbox_pkg::DATA_BITS-1:0]    prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [hmbox_pkg::SAMPLE_BITS-1:0]  sample_height,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [hmbox_pkg::ROW_BITS-1:0]     out_row,
	output logic [hmbox_pkg::COL_OUT_BITS-1:0] out_col,
	output logic [hmbox_pkg::SAMPLE_BITS-1:0]  out_height,
	output logic                               run_last
);
	import hmbox_pkg::*;

	logic [ROWS_REG_BITS-1:0] grid_rows_q;
	logic [COLS_REG_BITS-1:0] grid_cols_q;
	logic                     cfg_wr;
	hmbox_cfg_t               cfg;
	hmbox_qwr_t               qwr;
	hmbox_entry_t             q_head;
	logic                     q_head_valid;
	logic                     q_pop;
	logic [QCNT_BITS-1:0]     q_count;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= ROWS_REG_BITS'(MAX_ROWS);
			grid_cols_q <= COLS_REG_BITS'(MAX_COLS_DEF);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_GRID_ROWS: grid_rows_q <= pwdata[ROWS_REG_BITS-1:0];
				REG_GRID_COLS: grid_cols_q <= pwdata[COLS_REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_GRID_ROWS: prdata = DATA_BITS'(grid_rows_q);
			REG_GRID_COLS: prdata = DATA_BITS'(grid_cols_q);
			default:       prdata = '0;
		endcase
	end

	always_comb begin
		cfg.restart = cfg_wr;
		cfg.rows    = grid_rows_q;
		cfg.cols    = grid_cols_q;
	end

	hmbox_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_height(sample_height),
		.q_count      (q_count),
		.qwr          (qwr)
	);

	hmbox_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (qwr),
		.pop       (q_pop),
		.head      (q_head),
		.head_valid(q_head_valid),
		.count     (q_count)
	);

	hmbox_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.head_valid(q_head_valid),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_height(out_height),
		.run_last  (run_last)
	);

	// queue never pushed while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(qwr.push && !q_pop && (q_count == QCNT_BITS'(QDEPTH))))
		else $error("queue overflow");

	// back never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_count != '0))
		else $error("queue underflow");

	// an accepted sample always finds room ahead of it
	a_accept_room: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> (q_count < QCNT_BITS'(QDEPTH)))
		else $error("sample accepted with full queue");

endmodule
